[rtl/ckb_pkg.sv]
package ckb_pkg;

  localparam int unsigned CFG_W        = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned PIXEL_BITS   = 32;
  localparam int unsigned MAX_SIDE     = 4096;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_BASE    = 3'd0,
    CFG_DST_BASE    = 3'd1,
    CFG_SRC_STRIDE  = 3'd2,
    CFG_DST_STRIDE  = 3'd3,
    CFG_RECT_WIDTH  = 3'd4,
    CFG_RECT_HEIGHT = 3'd5,
    CFG_COLOR_KEY   = 3'd6,
    CFG_KEY_ENABLE  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
    logic [31:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [31:0] read_addr;
    logic        read_valid;
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic        write_enable;
    logic        last;
    logic        status;
  } out_t;

  // registers shared by front and back (the key lives apart, it is PIXEL_BITS wide)
  typedef struct packed {
    logic [31:0] src_base;
    logic [31:0] dst_base;
    logic [15:0] src_stride;
    logic [15:0] dst_stride;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic        key_enable;
  } cfg_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic        is_pixel;
    logic [31:0] src_off;
    logic [31:0] dst_off;
    logic [31:0] pixel;
    logic        key_hit;
  } entry_t;

endpackage

[rtl/ckb_stream_if.sv]
interface ckb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ckb_front.sv]
module ckb_front #(
  parameter int unsigned PIXEL_BITS = ckb_pkg::PIXEL_BITS
) (
  ckb_stream_if.sink              in_ch,
  input  ckb_pkg::cfg_t           cfg_i,
  input  logic [PIXEL_BITS-1:0]   key_i,
  input  logic                    full_i,
  output logic                    push_o,
  output ckb_pkg::entry_t         entry_o
);

  localparam int unsigned BPP = (PIXEL_BITS + 7) / 8;

  logic [27:0]           src_prod;
  logic [27:0]           dst_prod;
  logic [PIXEL_BITS-1:0] pix;

  assign in_ch.ready = !full_i;
  assign push_o      = in_ch.valid && !full_i;

  assign src_prod = 28'(in_ch.data.src_y) * 28'(cfg_i.src_stride);
  assign dst_prod = 28'(in_ch.data.dst_y) * 28'(cfg_i.dst_stride);
  assign pix      = in_ch.data.pixel_in[PIXEL_BITS-1:0];

  always_comb begin
    entry_o.is_pixel = (in_ch.data.mode == ckb_pkg::MODE_PIXEL);
    entry_o.src_off  = 32'(src_prod) + 32'(in_ch.data.src_x) * 32'(BPP);
    entry_o.dst_off  = 32'(dst_prod) + 32'(in_ch.data.dst_x) * 32'(BPP);
    entry_o.pixel    = 32'(pix);
    entry_o.key_hit  = cfg_i.key_enable && (pix == key_i);
  end

endmodule

[rtl/ckb_fifo.sv]
module ckb_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = ckb_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/ckb_back.sv]
module ckb_back #(
  parameter int unsigned PIXEL_BITS = ckb_pkg::PIXEL_BITS,
  parameter int unsigned MAX_SIDE   = ckb_pkg::MAX_SIDE
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ckb_pkg::cfg_t   cfg_i,
  input  logic            empty_i,
  input  ckb_pkg::entry_t entry_i,
  output logic            pop_o,
  ckb_stream_if.source    out_ch
);

  localparam int unsigned BPP   = (PIXEL_BITS + 7) / 8;
  localparam int unsigned CNT_W = $clog2(MAX_SIDE);
  localparam int unsigned EW    = $clog2(MAX_SIDE + 1);

  logic [31:0]      srow_q, srow_d;
  logic [31:0]      drow_q, drow_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             busy_q, busy_d;
  ckb_pkg::out_t    out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [EW-1:0]    eff_w;
  logic [EW-1:0]    eff_h;
  logic             row_end;
  logic             copy_end;
  logic [31:0]      col_off;

  assign eff_w = (32'(cfg_i.rect_width) > 32'(MAX_SIDE)) ? EW'(MAX_SIDE)
                                                          : EW'(cfg_i.rect_width);
  assign eff_h = (32'(cfg_i.rect_height) > 32'(MAX_SIDE)) ? EW'(MAX_SIDE)
                                                           : EW'(cfg_i.rect_height);

  assign row_end  = (EW'(col_q) + EW'(1)) >= eff_w;
  assign copy_end = (EW'(row_q) + EW'(1)) >= eff_h;
  assign col_off  = 32'(col_q) * 32'(BPP);

  // take the next beat whenever the output register is free or being drained
  assign pop_o        = !empty_i && (!out_valid_q || out_ch.ready);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  always_comb begin
    srow_d      = srow_q;
    drow_d      = drow_q;
    col_d       = col_q;
    row_d       = row_q;
    busy_d      = busy_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (!entry_i.is_pixel) begin
        srow_d = cfg_i.src_base + entry_i.src_off;
        drow_d = cfg_i.dst_base + entry_i.dst_off;
        col_d  = '0;
        row_d  = '0;
        if (eff_w == '0 || eff_h == '0) begin
          busy_d       = 1'b0;
          out_d.last   = 1'b1;
        end else begin
          busy_d           = 1'b1;
          out_d.read_addr  = srow_d;
          out_d.read_valid = 1'b1;
        end
      end else if (!busy_q) begin
        out_d.status = 1'b1;
      end else begin
        out_d.write_addr   = drow_q + col_off;
        out_d.write_data   = entry_i.pixel;
        out_d.write_enable = !entry_i.key_hit;
        if (row_end) begin
          col_d  = '0;
          srow_d = srow_q + 32'(cfg_i.src_stride);
          drow_d = drow_q + 32'(cfg_i.dst_stride);
          if (copy_end) begin
            row_d      = '0;
            busy_d     = 1'b0;
            out_d.last = 1'b1;
          end else begin
            row_d            = row_q + CNT_W'(1);
            out_d.read_addr  = srow_d;
            out_d.read_valid = 1'b1;
          end
        end else begin
          col_d            = col_q + CNT_W'(1);
          out_d.read_addr  = srow_q + col_off + 32'(BPP);
          out_d.read_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srow_q      <= '0;
      drow_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      srow_q      <= srow_d;
      drow_q      <= drow_d;
      col_q       <= col_d;
      row_q       <= row_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> !busy_q)
    else $error("last delivered while copy still running");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.read_valid == busy_q))
    else $error("read_valid out of step with busy state");

  a_status_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> !out_q.write_enable && !out_q.read_valid)
    else $error("idle pixel beat produced a write or read");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i && (!out_valid_q || out_ch.ready))
    else $error("queue popped without room");

endmodule

[rtl/color_keyed_block_copy.sv]
// Color-keyed block copy sequencer.
// in_ch carries one beat per item: mode 0 starts a copy with the source and
// destination offsets, mode 1 brings the source pixel read at the last given
// read address. out_ch returns exactly one beat per input beat, in order: the
// next read address, and for pixels the destination address, data and write
// enable (low when the pixel matches the color key with keying on).
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only
// while no beat is in flight (the block does not enforce this); they are not read back.
// An accepted input beat is written into the queue, and from there into the
// output register, from which its result is taken.
// Throughput: one item per cycle while out_ch is ready, set by the state update
// of the back-end address walker.
// A two-entry queue separates the front classifier from the back end; in_ch
// stays ready while the queue has room, so a stalled receiver holds the
// output register and backs up into the queue before in_ch drops ready.
// Reset clears all registers, the queue and the copy state (idle).
module color_keyed_block_copy #(
  parameter int unsigned PIXEL_BITS  = ckb_pkg::PIXEL_BITS,
  parameter int unsigned MAX_SIDE    = ckb_pkg::MAX_SIDE,
  parameter int unsigned QUEUE_DEPTH = ckb_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ckb_stream_if.sink                    in_ch,
  ckb_stream_if.source                  out_ch,
  input  logic                          cfg_we_i,
  input  logic [ckb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ckb_pkg::CFG_W-1:0]     cfg_data_i
);

  ckb_pkg::cfg_t          cfg_q, cfg_d;
  logic [PIXEL_BITS-1:0]  key_q, key_d;

  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  ckb_pkg::entry_t        entry_in;
  ckb_pkg::entry_t        entry_out;

  always_comb begin
    cfg_d = cfg_q;
    key_d = key_q;
    if (cfg_we_i) begin
      case (ckb_pkg::cfg_idx_e'(cfg_idx_i))
        ckb_pkg::CFG_SRC_BASE:    cfg_d.src_base    = cfg_data_i;
        ckb_pkg::CFG_DST_BASE:    cfg_d.dst_base    = cfg_data_i;
        ckb_pkg::CFG_SRC_STRIDE:  cfg_d.src_stride  = cfg_data_i[15:0];
        ckb_pkg::CFG_DST_STRIDE:  cfg_d.dst_stride  = cfg_data_i[15:0];
        ckb_pkg::CFG_RECT_WIDTH:  cfg_d.rect_width  = cfg_data_i[12:0];
        ckb_pkg::CFG_RECT_HEIGHT: cfg_d.rect_height = cfg_data_i[12:0];
        ckb_pkg::CFG_COLOR_KEY:   key_d             = cfg_data_i[PIXEL_BITS-1:0];
        ckb_pkg::CFG_KEY_ENABLE:  cfg_d.key_enable  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      key_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      key_q <= key_d;
    end
  end

  ckb_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .in_ch   (in_ch),
    .cfg_i   (cfg_q),
    .key_i   (key_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in)
  );

  ckb_fifo #(
    .T     (ckb_pkg::entry_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .data_o  (entry_out),
    .full_o  (full),
    .empty_o (empty)
  );

  ckb_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_SIDE   (MAX_SIDE)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .entry_i (entry_out),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
